FILE: rtl/ssip_pkg.sv
// ----------------------------------------------------------------------------
// ssip_pkg: shared definitions for the sorted search insert position unit
// Table geometry, operation codes and the request/response structs that pass
// between the top level and the search sequencer.
// ----------------------------------------------------------------------------
package ssip_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = 32;
    localparam int IDX_W = 11;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    typedef struct packed {
        logic                 start;
        logic signed [DW-1:0] key;
        logic [CW-1:0]        count;
    } srch_req_t;

    typedef struct packed {
        logic          done;
        logic [CW-1:0] index;
        logic          found;
    } srch_rsp_t;

endpackage

FILE: rtl/ssip_table.sv
// ----------------------------------------------------------------------------
// ssip_table: value table storage
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssip_table
    import ssip_pkg::*;
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/ssip_search.sv
// ----------------------------------------------------------------------------
// ssip_search: binary search sequencer
// Issues one table read per cycle and narrows the half-open window [left, hi)
// with an equality and a signed compare, tracking the lowest greater probe.
// ----------------------------------------------------------------------------
module ssip_search
    import ssip_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  srch_req_t     req,
    input  logic [DW-1:0] rd_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    output logic          busy,
    output srch_rsp_t     rsp
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_PROBE = 2'b10
    } srch_state_t;

    srch_state_t          state_reg, state_next;
    logic [CW-1:0]        left_reg, left_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [CW-1:0]        mid_reg, mid_next;
    logic [CW-1:0]        bound_reg, bound_next;
    logic signed [DW-1:0] key_reg, key_next;
    logic                 is_eq;
    logic                 is_gt;
    logic                 finish;

    assign is_eq = (rd_data == key_reg);
    assign is_gt = ($signed(rd_data) > key_reg);

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        hi_next    = hi_reg;
        bound_next = bound_reg;
        key_next   = key_reg;
        finish     = 1'b0;
        rsp        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    left_next  = '0;
                    hi_next    = req.count;
                    bound_next = req.count;
                    key_next   = req.key;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (is_eq)
                begin
                    finish    = 1'b1;
                    rsp.index = mid_reg;
                    rsp.found = 1'b1;
                end
                else
                begin
                    if (is_gt)
                    begin
                        bound_next = mid_reg;
                        hi_next    = mid_reg;
                    end
                    else
                    begin
                        left_next = mid_reg + CW'(1);
                    end
                    if (left_next >= hi_next)
                    begin
                        finish    = 1'b1;
                        rsp.index = bound_next;
                    end
                end
                if (finish)
                begin
                    rsp.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // Midpoint of the next window; the difference is nonnegative whenever used.
        mid_next = left_next + ((hi_next - left_next - CW'(1)) >> 1);
    end

    assign rd_addr = mid_next[AW-1:0];
    assign rd_en   = ((state_reg == S_IDLE) && req.start) ||
                     ((state_reg == S_PROBE) && !finish);
    assign busy    = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        bound_reg <= bound_next;
        key_reg   <= key_next;
    end

endmodule

FILE: rtl/sorted_search_insert_position_unit.sv
// ----------------------------------------------------------------------------
// sorted_search_insert_position_unit: sorted table with binary search
// Holds up to 1024 signed values loaded by appends and answers searches with
// the matching position or the insert position.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation. The result of a clear or an
// append is registered at the acceptance edge. A search has a start step,
// then one probe after another, because every probe is one read of the
// single table read port followed by its compares. A search on an empty
// table is answered at once with position zero, registered at the
// acceptance edge. While a search runs, item_stall is high. A new transfer
// is also held off while a finished result waits in the output register and
// result_stall is high. The table contents are not reset; a clear only
// resets the fill count, and searches read only entries below that count.
// An append to a full table is dropped and reports full_error with index
// equal to the count. Op code 3 changes nothing and returns an all-zero
// result.
// ----------------------------------------------------------------------------
module sorted_search_insert_position_unit
    import ssip_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [1:0]           op,
    input  logic signed [DW-1:0] value,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [IDX_W-1:0]     index,
    output logic                 found,
    output logic                 full_error
);

    logic               accept;
    logic               srch_busy;
    srch_req_t          srch_req;
    srch_rsp_t          srch_rsp;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [DW-1:0]      rd_data;
    logic               wr_en;

    logic [CW-1:0]      count_reg, count_next;
    logic               result_valid_reg, result_valid_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic               found_reg, found_next;
    logic               full_error_reg, full_error_next;

    // A transfer is taken only when no search is running and the output
    // register will be free at the same edge.
    assign item_stall = srch_busy || (result_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        count_next        = count_reg;
        result_valid_next = result_valid_reg && result_stall;
        index_next        = index_reg;
        found_next        = found_reg;
        full_error_next   = full_error_reg;
        wr_en             = 1'b0;
        srch_req.start    = 1'b0;
        srch_req.key      = value;
        srch_req.count    = count_reg;

        if (srch_rsp.done)
        begin
            // The output register was emptied when the search was accepted.
            result_valid_next = 1'b1;
            index_next        = IDX_W'(srch_rsp.index);
            found_next        = srch_rsp.found;
            full_error_next   = 1'b0;
        end

        if (accept)
        begin
            index_next      = '0;
            found_next      = 1'b0;
            full_error_next = 1'b0;
            case (op)
                OP_CLEAR:
                begin
                    count_next        = '0;
                    result_valid_next = 1'b1;
                end
                OP_APPEND:
                begin
                    result_valid_next = 1'b1;
                    index_next        = IDX_W'(count_reg);
                    if (count_reg < CW'(DEPTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        full_error_next = 1'b1;
                    end
                end
                OP_SEARCH:
                begin
                    if (count_reg == '0)
                    begin
                        // Empty table answers at once with position zero.
                        result_valid_next = 1'b1;
                    end
                    else
                    begin
                        srch_req.start    = 1'b1;
                        result_valid_next = 1'b0;
                    end
                end
                default:
                begin
                    result_valid_next = 1'b1;
                end
            endcase
        end
    end

    ssip_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ssip_search u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (srch_req),
        .rd_data (rd_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .busy    (srch_busy),
        .rsp     (srch_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg      <= index_next;
        found_reg      <= found_next;
        full_error_reg <= full_error_next;
    end

    assign result_valid = result_valid_reg;
    assign index        = index_reg;
    assign found        = found_reg;
    assign full_error   = full_error_reg;

endmodule
